[hdl/ptps_pkg.sv]
// shared types, constants and helpers for the point-to-primitive surface block
// no dependencies; used by the interfaces and by every module

package ptps_pkg;

  localparam int DATA_W           = 32;
  localparam int SIZE_W           = 31;
  localparam int DIV_W            = 64;
  localparam int CFG_IDX_W        = 2;
  localparam int NEWTON_STEPS_DEF = 64;
  localparam int CYL_NEWTON_STEPS = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
  localparam logic [DIV_W-1:0]  ONE_Q30    = DIV_W'(1) << 30;
  localparam logic [DIV_W-1:0]  ONE_Q60    = DIV_W'(1) << 60;

  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_CYL    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE  = 2'd0,
    REG_SIZE_A = 2'd1,
    REG_SIZE_B = 2'd2,
    REG_SIZE_C = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_ACC,
    ST_NT_START,
    ST_NT_WAIT,
    ST_SC_MUL,
    ST_SC_START,
    ST_SC_WAIT,
    ST_RT_CHK,
    ST_RT_WAIT,
    ST_RT_MUL,
    ST_RT_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) return hi[DATA_W-1:0];
    else if (v < lo) return lo[DATA_W-1:0];
    else return v[DATA_W-1:0];
  endfunction

endpackage

[hdl/ptps_pt_if.sv]
// query point channel: valid/ready plus three signed q16.16 coordinates
// depends on ptps_pkg

interface ptps_pt_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptps_pkg::DATA_W-1:0]  point_x;
  logic signed [ptps_pkg::DATA_W-1:0]  point_y;
  logic signed [ptps_pkg::DATA_W-1:0]  point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

[hdl/ptps_res_if.sv]
// result channel: valid/ready plus flags and the vector to the surface
// depends on ptps_pkg

interface ptps_res_if;
  logic                                valid;
  logic                                ready;
  logic                                shape_known;
  logic                                is_inside;
  logic signed [ptps_pkg::DATA_W-1:0]  to_surface_x;
  logic signed [ptps_pkg::DATA_W-1:0]  to_surface_y;
  logic signed [ptps_pkg::DATA_W-1:0]  to_surface_z;
  modport source (output valid, shape_known, is_inside, to_surface_x, to_surface_y,
                  to_surface_z, input ready);
  modport sink (input valid, shape_known, is_inside, to_surface_x, to_surface_y,
                to_surface_z, output ready);
endinterface

[hdl/ptps_cfg_if.sv]
// configuration write channel: valid/ready, register index and write data
// depends on ptps_pkg

interface ptps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ptps_pkg::CFG_IDX_W-1:0]    index;
  logic [ptps_pkg::SIZE_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/ptps_mul.sv]
// shared 32x32 unsigned multiplier with registered product
// depends on ptps_pkg

module ptps_mul (
  input  logic                            clk,
  input  logic [ptps_pkg::DATA_W-1:0]     a,
  input  logic [ptps_pkg::DATA_W-1:0]     b,
  output logic [2*ptps_pkg::DATA_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[hdl/ptps_div.sv]
// shared unsigned restoring divider, one quotient bit per cycle
// depends on ptps_pkg (request and response structs)

module ptps_div (
  input  logic                clk,
  input  logic                rst,
  input  ptps_pkg::div_req_t  req,
  output ptps_pkg::div_rsp_t  rsp
);

  localparam int W  = ptps_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  den;
  logic [CW-1:0] cnt;
  logic          done;
  logic [W:0]    rem_sh;
  logic          ge;
  logic [W:0]    diff;

  assign rem_sh = {rem, quo[W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (cnt != '0) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign rsp.busy = cnt != '0;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

[hdl/point_to_primitive_surface.sv]
// top level: sequencer over one shared multiplier and one shared divider
// depends on ptps_pkg, ptps_pt_if, ptps_res_if, ptps_cfg_if, ptps_mul, ptps_div
//
//   channel | dir | handshake   | word
//   pt      | in  | valid/ready | point_x, point_y, point_z
//   res     | out | valid/ready | shape_known, is_inside, to_surface_x/y/z
//   cfg     | in  | valid/ready | index, data (always ready)
//
// box and unknown shape: no multiply or divide. sphere: up to MAX_NEWTON_STEPS newton
// divides, then up to three scaling and three ratio divides; cylinder: up to 64 newton
// divides, then up to two scaling divides.
// one word at a time; a finished word waits in the output register while the next
// point is taken. rst is synchronous and clears control state and configuration only.

module point_to_primitive_surface #(
  parameter int MAX_NEWTON_STEPS = ptps_pkg::NEWTON_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ptps_pt_if.sink      pt,
  ptps_res_if.source   res,
  ptps_cfg_if.sink     cfg
);

  localparam int DW      = ptps_pkg::DATA_W;
  localparam int W       = ptps_pkg::DIV_W;
  localparam int SW      = ptps_pkg::SIZE_W;
  localparam int LIM_MAX = (MAX_NEWTON_STEPS > ptps_pkg::CYL_NEWTON_STEPS) ?
                           MAX_NEWTON_STEPS : ptps_pkg::CYL_NEWTON_STEPS;
  localparam int IW      = $clog2(LIM_MAX + 1);

  ptps_pkg::state_t   state;
  ptps_pkg::state_t   state_next;
  ptps_pkg::kind_t    kind;
  ptps_pkg::div_req_t div_req;
  ptps_pkg::div_rsp_t div_rsp;

  logic [SW-1:0] size [3];

  logic signed [DW-1:0] p [3];
  logic [DW-1:0]        m [3];
  logic signed [W-1:0]  sc [3];
  logic [W-1:0]         acc_sq;
  logic [W-1:0]         sum;
  logic [W-1:0]         y;
  logic [W-1:0]         racc;
  logic                 fail;
  logic [IW-1:0]        iter;
  logic [1:0]           axis;

  logic [DW-1:0]   mul_a;
  logic [DW-1:0]   mul_b;
  logic [2*DW-1:0] prod;

  logic          is_sph;
  logic [W-1:0]  sq_sum;
  logic [W-1:0]  guess;
  logic [W:0]    nt_sum;
  logic [W-1:0]  nt_nxt;
  logic [IW-1:0] lim_m1;
  logic          nt_end;
  logic          out_load;

  ptps_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  ptps_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign is_sph   = kind == ptps_pkg::KIND_SPHERE;
  assign sq_sum   = acc_sq + prod;
  assign guess    = is_sph ? (W'(m[0]) + W'(m[1]) + W'(m[2])) : (W'(m[1]) + W'(m[2]));
  assign nt_sum   = {1'b0, y} + {1'b0, div_rsp.quo};
  assign nt_nxt   = nt_sum[W:1];
  assign lim_m1   = is_sph ? IW'(MAX_NEWTON_STEPS - 1) : IW'(ptps_pkg::CYL_NEWTON_STEPS - 1);
  assign nt_end   = (nt_nxt >= y) || (iter == lim_m1);
  assign out_load = (state == ptps_pkg::ST_FIN) && (!res.valid || res.ready);

  assign pt.ready  = state == ptps_pkg::ST_IDLE;
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= ptps_pkg::KIND_BOX;
      size[0] <= ptps_pkg::SIZE_RESET;
      size[1] <= ptps_pkg::SIZE_RESET;
      size[2] <= ptps_pkg::SIZE_RESET;
    end else if (cfg.valid) begin
      case (ptps_pkg::reg_idx_t'(cfg.index))
        ptps_pkg::REG_SHAPE:  kind    <= ptps_pkg::kind_t'(cfg.data[1:0]);
        ptps_pkg::REG_SIZE_A: size[0] <= cfg.data;
        ptps_pkg::REG_SIZE_B: size[1] <= cfg.data;
        ptps_pkg::REG_SIZE_C: size[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ptps_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    div_req     = '0;
    mul_a       = '0;
    mul_b       = '0;
    case (state)
      ptps_pkg::ST_IDLE: begin
        if (pt.valid) begin
          case (kind)
            ptps_pkg::KIND_SPHERE: state_next = ptps_pkg::ST_SQ_X;
            ptps_pkg::KIND_CYL:    state_next = ptps_pkg::ST_SQ_Y;
            default:               state_next = ptps_pkg::ST_FIN;
          endcase
        end
      end
      ptps_pkg::ST_SQ_X: begin
        mul_a = m[0]; mul_b = m[0];
        state_next = ptps_pkg::ST_SQ_Y;
      end
      ptps_pkg::ST_SQ_Y: begin
        mul_a = m[1]; mul_b = m[1];
        state_next = ptps_pkg::ST_SQ_Z;
      end
      ptps_pkg::ST_SQ_Z: begin
        mul_a = m[2]; mul_b = m[2];
        state_next = ptps_pkg::ST_SQ_ACC;
      end
      ptps_pkg::ST_SQ_ACC: begin
        if (sq_sum != '0)  state_next = ptps_pkg::ST_NT_START;
        else if (is_sph)   state_next = ptps_pkg::ST_RT_CHK;
        else               state_next = ptps_pkg::ST_FIN;
      end
      ptps_pkg::ST_NT_START: begin
        div_req.start = 1'b1;
        div_req.num   = sum;
        div_req.den   = y;
        state_next    = ptps_pkg::ST_NT_WAIT;
      end
      ptps_pkg::ST_NT_WAIT: begin
        if (div_rsp.done) state_next = nt_end ? ptps_pkg::ST_SC_MUL : ptps_pkg::ST_NT_START;
      end
      ptps_pkg::ST_SC_MUL: begin
        mul_a = m[axis]; mul_b = {1'b0, size[0]};
        state_next = ptps_pkg::ST_SC_START;
      end
      ptps_pkg::ST_SC_START: begin
        div_req.start = 1'b1;
        div_req.num   = prod;
        div_req.den   = y;
        state_next    = ptps_pkg::ST_SC_WAIT;
      end
      ptps_pkg::ST_SC_WAIT: begin
        if (div_rsp.done) begin
          if (axis != 2'd2)  state_next = ptps_pkg::ST_SC_MUL;
          else if (is_sph)   state_next = ptps_pkg::ST_RT_CHK;
          else               state_next = ptps_pkg::ST_FIN;
        end
      end
      ptps_pkg::ST_RT_CHK: begin
        if (size[axis] == '0) begin
          if (m[axis] != '0 || axis == 2'd2) state_next = ptps_pkg::ST_FIN;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {2'b00, m[axis], 30'b0};
          div_req.den   = W'(size[axis]);
          state_next    = ptps_pkg::ST_RT_WAIT;
        end
      end
      ptps_pkg::ST_RT_WAIT: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quo > ptps_pkg::ONE_Q30) ? ptps_pkg::ST_FIN : ptps_pkg::ST_RT_MUL;
        end
      end
      ptps_pkg::ST_RT_MUL: begin
        mul_a = div_rsp.quo[DW-1:0]; mul_b = div_rsp.quo[DW-1:0];
        state_next = ptps_pkg::ST_RT_ACC;
      end
      ptps_pkg::ST_RT_ACC: begin
        state_next = (axis == 2'd2) ? ptps_pkg::ST_FIN : ptps_pkg::ST_RT_CHK;
      end
      ptps_pkg::ST_FIN: begin
        if (!res.valid || res.ready) state_next = ptps_pkg::ST_IDLE;
      end
      default: state_next = ptps_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ptps_pkg::ST_IDLE: begin
        p[0] <= pt.point_x; p[1] <= pt.point_y; p[2] <= pt.point_z;
        m[0] <= pt.point_x[DW-1] ? DW'(-pt.point_x) : pt.point_x;
        m[1] <= pt.point_y[DW-1] ? DW'(-pt.point_y) : pt.point_y;
        m[2] <= pt.point_z[DW-1] ? DW'(-pt.point_z) : pt.point_z;
        sc[0] <= '0; sc[1] <= '0; sc[2] <= '0;
        y     <= '0;
        racc  <= '0;
        fail  <= 1'b0;
        iter  <= '0;
      end
      // squares arrive from the registered multiplier product of the previous state
      ptps_pkg::ST_SQ_Y:   acc_sq <= is_sph ? prod : '0;
      ptps_pkg::ST_SQ_Z:   acc_sq <= acc_sq + prod;
      ptps_pkg::ST_SQ_ACC: begin
        sum  <= sq_sum;
        y    <= (sq_sum != '0) ? guess : '0;
        axis <= (sq_sum != '0 && !is_sph) ? 2'd1 : 2'd0;
      end
      ptps_pkg::ST_NT_WAIT: begin
        if (div_rsp.done && nt_nxt < y) begin
          y    <= nt_nxt;
          iter <= iter + IW'(1);
        end
      end
      ptps_pkg::ST_SC_WAIT: begin
        if (div_rsp.done) begin
          sc[axis] <= p[axis][DW-1] ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
          axis     <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
      end
      ptps_pkg::ST_RT_CHK: begin
        if (size[axis] == '0) begin
          if (m[axis] != '0) fail <= 1'b1;
          else axis <= axis + 2'd1;
        end
      end
      ptps_pkg::ST_RT_WAIT: begin
        if (div_rsp.done && div_rsp.quo > ptps_pkg::ONE_Q30) fail <= 1'b1;
      end
      ptps_pkg::ST_RT_ACC: begin
        racc <= racc + prod;
        axis <= axis + 2'd1;
      end
      default: ;
    endcase
  end

  // surface point and inside flag from the gathered terms
  logic signed [W-1:0] ps [3];
  logic signed [W-1:0] s  [3];
  logic signed [W-1:0] d  [3];
  logic signed [W-1:0] f  [3];
  logic [W-1:0]        face_gap [3];
  logic                outside [3];
  logic [1:0]          best;
  logic signed [W-1:0] rad;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] cap;
  logic signed [W-1:0] r;
  logic                known;
  logic                in_prim;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps[i] = W'(p[i]);
      d[i]  = W'(size[i][SW-1:1]);
      outside[i] = 1'b0;
      if (ps[i] > d[i]) begin
        f[i] = d[i]; outside[i] = 1'b1;
      end else if (ps[i] < -d[i]) begin
        f[i] = -d[i]; outside[i] = 1'b1;
      end else begin
        f[i] = (ps[i] > 0) ? d[i] : -d[i];
      end
      face_gap[i] = (f[i] >= ps[i]) ? W'(f[i] - ps[i]) : W'(ps[i] - f[i]);
    end
    best = 2'd0;
    if (face_gap[1] < face_gap[0]) best = 2'd1;
    if (face_gap[2] < face_gap[best]) best = 2'd2;

    rad = W'(size[0]);
    dx  = d[1];
    r   = $signed(y);
    cap = dx - rad + r;

    known   = 1'b1;
    in_prim = 1'b1;
    s[0] = '0; s[1] = '0; s[2] = '0;
    case (kind)
      ptps_pkg::KIND_BOX: begin
        in_prim = !(outside[0] || outside[1] || outside[2]);
        for (int i = 0; i < 3; i++) begin
          if (i == int'(best)) s[i] = f[i];
          else if (ps[i] > d[i]) s[i] = d[i];
          else if (ps[i] < -d[i]) s[i] = -d[i];
          else s[i] = ps[i];
        end
      end
      ptps_pkg::KIND_SPHERE: begin
        in_prim = !fail && (racc <= ptps_pkg::ONE_Q60);
        s[0] = sc[0]; s[1] = sc[1]; s[2] = sc[2];
      end
      ptps_pkg::KIND_CYL: begin
        in_prim = !(r > rad || ps[0] > dx || ps[0] < -dx);
        if (r == 0) begin
          if (rad < dx) s[1] = rad;
          else s[0] = (ps[0] > 0) ? dx : -dx;
        end else if (ps[0] > cap || ps[0] < -cap) begin
          // end-cap region
          s[1] = (r > rad) ? sc[1] : ps[1];
          s[2] = (r > rad) ? sc[2] : ps[2];
          if (ps[0] > 0) s[0] = dx;
          else if (ps[0] < 0) s[0] = -dx;
          else s[0] = ps[0];
        end else begin
          s[1] = sc[1];
          s[2] = sc[2];
          if (ps[0] > dx) s[0] = dx;
          else if (ps[0] < -dx) s[0] = -dx;
          else s[0] = ps[0];
        end
      end
      default: begin
        known   = 1'b0;
        in_prim = 1'b0;
        s[0] = ps[0]; s[1] = ps[1]; s[2] = ps[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.shape_known  <= known;
      res.is_inside    <= in_prim;
      res.to_surface_x <= ptps_pkg::sat32(s[0] - ps[0]);
      res.to_surface_y <= ptps_pkg::sat32(s[1] - ps[1]);
      res.to_surface_z <= ptps_pkg::sat32(s[2] - ps[2]);
    end
  end

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= IW'(LIM_MAX))
    else $error("newton step count out of range");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ptps_pkg::ST_FIN))
    else $error("result raised outside finish");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.shape_known) |->
    (!res.is_inside && res.to_surface_x == 0 && res.to_surface_y == 0 &&
     res.to_surface_z == 0))
    else $error("unknown shape gave nonzero result");

  a_wait_div: assert property (@(posedge clk) disable iff (rst)
    (state == ptps_pkg::ST_NT_WAIT && !div_rsp.done) |-> div_rsp.busy)
    else $error("waiting on idle divider");
`endif

endmodule
